@@ rtl/cjst_pkg.sv @@
// ----------------------------------------------------------------------------
// cjst_pkg
// Shared types and constants for the client join slot table.
// ----------------------------------------------------------------------------
package cjst_pkg;

   localparam int ADDR_W    = 48;
   localparam int ID_W      = 8;
   localparam int SLOTS_W   = 8;
   localparam int INDEX_W   = 5;
   localparam int RIDX_W    = 8;
   localparam int JOINED_W  = 6;
   localparam int STATUS_W  = 3;

   localparam logic CMD_JOIN = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [SLOTS_W-1:0] MAX_SLOTS_RESET = 8'd8;
   localparam logic [ID_W-1:0]    ID_EMPTY        = 8'd0;
   localparam logic [ID_W-1:0]    ID_LIMIT        = 8'd255;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 3'd0,
      STS_TOO_MANY  = 3'd1,
      STS_DUPLICATE = 3'd2,
      STS_FULL      = 3'd3,
      STS_BAD_INDEX = 3'd4
   } status_type;

   typedef struct packed {
      logic                en;
      logic [INDEX_W-1:0]  index;
      logic [ID_W-1:0]     id;
      logic [ADDR_W-1:0]   address;
   } entry_write_type;

endpackage

@@ rtl/client_join_slot_table_core.sv @@
// ----------------------------------------------------------------------------
// client_join_slot_table_core
// Join table for a slotted wireless server: admits stations, detects
// duplicates and full tables, and answers entry reads.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Contents
//  req      in         req_tvalid/req_tready  join or read request item
//  rsp      out        rsp_tvalid/rsp_tready  one result item per request
//  csr      in         csr_valid/csr_ready    max_slots_per_client
//
//  A join steps one address comparator over the entries, one per cycle,
//  then writes the free entry unless it met a duplicate or found none free.
//  A read passes through S_READ to S_FINISH; a refused or out-of-range
//  request goes straight to S_FINISH. Reset empties the table at once; the
//  result register lets the next item be taken while a result waits on rsp.
// ----------------------------------------------------------------------------
module client_join_slot_table_core
   import cjst_pkg::*;
#(
   parameter int TABLE_ENTRIES = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // station_address, slot_count, read_index
   input  logic        req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // status, entry_index, client_number, client_address
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_READ   = 5'b00100,
      S_COMMIT = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [SLOTS_W-1:0]   max_slots_ff;
   logic [SLOTS_W-1:0]   slots_ff, slots_in;
   logic [JOINED_W-1:0]  joined_ff, joined_in;
   logic [ADDR_W-1:0]    req_addr_ff, req_addr_in;
   logic [SLOTS_W-1:0]   req_want_ff, req_want_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [IDX_W-1:0]     free_ff, free_in;
   logic                 free_found_ff, free_found_in;
   status_type           res_status_ff, res_status_in;
   logic [INDEX_W-1:0]   res_index_ff, res_index_in;
   logic [ID_W-1:0]      res_id_ff, res_id_in;
   logic [ADDR_W-1:0]    res_addr_ff, res_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          rsp_data_ff, rsp_data_in;

   entry_write_type      wr;
   logic [ID_W-1:0]      rd_id;
   logic [ADDR_W-1:0]    rd_address;
   logic                 req_accept;
   logic                 out_free;
   logic                 req_cmd;
   logic [ADDR_W-1:0]    req_addr;
   logic [SLOTS_W-1:0]   req_want;
   logic [RIDX_W-1:0]    req_ridx;
   logic [SLOTS_W:0]     id_sum;
   logic [SLOTS_W:0]     total_sum;
   logic [SLOTS_W-1:0]   grant;

   assign req_cmd  = req_tuser;
   assign req_addr = req_tdata[47:0];
   assign req_want = req_tdata[55:48];
   assign req_ridx = req_tdata[63:56];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign grant     = (req_want_ff > 8'd1) ? req_want_ff : 8'd1;
   assign id_sum    = {1'b0, slots_ff} + 9'd1;
   assign total_sum = {1'b0, slots_ff} + {1'b0, grant};

   cjst_entry_store #(
      .ENTRIES (TABLE_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .rd_index   (scan_ff),
      .rd_id      (rd_id),
      .rd_address (rd_address)
   );

   always_comb begin
      state_in      = state_ff;
      slots_in      = slots_ff;
      joined_in     = joined_ff;
      req_addr_in   = req_addr_ff;
      req_want_in   = req_want_ff;
      scan_in       = scan_ff;
      free_in       = free_ff;
      free_found_in = free_found_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_id_in     = res_id_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      wr            = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               req_addr_in   = req_addr;
               req_want_in   = req_want;
               res_index_in  = '0;
               res_id_in     = ID_EMPTY;
               res_addr_in   = '0;
               scan_in       = '0;
               free_found_in = 1'b0;
               if (req_cmd == CMD_READ) begin
                  if (req_ridx >= RIDX_W'(TABLE_ENTRIES)) begin
                     res_status_in = STS_BAD_INDEX;
                     state_in      = S_FINISH;
                  end else begin
                     scan_in  = req_ridx[IDX_W-1:0];
                     state_in = S_READ;
                  end
               end else if (req_want > max_slots_ff) begin
                  res_status_in = STS_TOO_MANY;
                  state_in      = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (rd_id != ID_EMPTY && rd_address == req_addr_ff) begin
               res_status_in = STS_DUPLICATE;
               res_index_in  = INDEX_W'(scan_ff);
               state_in      = S_FINISH;
            end else begin
               if (rd_id == ID_EMPTY && !free_found_ff) begin
                  free_in       = scan_ff;
                  free_found_in = 1'b1;
               end
               if (scan_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
                  state_in = S_COMMIT;
               end else begin
                  scan_in = scan_ff + IDX_W'(1);
               end
            end
         end
         S_READ: begin
            res_status_in = STS_OK;
            res_index_in  = INDEX_W'(scan_ff);
            res_id_in     = rd_id;
            res_addr_in   = rd_address;
            state_in      = S_FINISH;
         end
         S_COMMIT: begin
            if (free_found_ff) begin
               wr.en         = 1'b1;
               wr.index      = INDEX_W'(free_ff);
               wr.id         = id_sum[SLOTS_W] ? ID_LIMIT : id_sum[ID_W-1:0];
               wr.address    = req_addr_ff;
               slots_in      = total_sum[SLOTS_W] ? 8'hFF : total_sum[SLOTS_W-1:0];
               joined_in     = joined_ff + JOINED_W'(1);
               res_status_in = STS_OK;
               res_index_in  = INDEX_W'(free_ff);
            end else begin
               res_status_in = STS_FULL;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_addr_ff, res_id_ff, res_index_ff, res_status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         max_slots_ff  <= MAX_SLOTS_RESET;
         slots_ff      <= '0;
         joined_ff     <= '0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slots_ff      <= slots_in;
         joined_ff     <= joined_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_slots_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_addr_ff   <= req_addr_in;
      req_want_ff   <= req_want_in;
      scan_ff       <= scan_in;
      free_ff       <= free_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_id_ff     <= res_id_in;
      res_addr_ff   <= res_addr_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The slot total only ever grows or holds at its ceiling.
   a_slots_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> slots_ff >= $past(slots_ff))
      else $error("slot total decreased");

   // A new result is only loaded from the finishing state.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(state_ff == S_FINISH))
      else $error("result appeared outside the finishing state");

   // The joined count changes only when an entry is committed.
   a_joined_on_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && joined_ff != $past(joined_ff)) |-> $past(wr.en))
      else $error("joined count changed without an entry write");

   // A written entry is never marked empty.
   a_write_nonzero_id: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (wr.id != ID_EMPTY && state_ff == S_COMMIT))
      else $error("entry written with an empty id");

endmodule

@@ rtl/cjst_entry_store.sv @@
// ----------------------------------------------------------------------------
// cjst_entry_store
// Entry store of the join table: one id and one station address per entry,
// written at one entry and read at one entry per cycle.
// ----------------------------------------------------------------------------
module cjst_entry_store
   import cjst_pkg::*;
#(
   parameter int ENTRIES = 5,
   parameter int IDX_W   = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  entry_write_type     wr,
   input  logic [IDX_W-1:0]    rd_index,
   output logic [ID_W-1:0]     rd_id,
   output logic [ADDR_W-1:0]   rd_address
);

   logic [ID_W-1:0]   ids_ff   [ENTRIES];
   logic [ADDR_W-1:0] addrs_ff [ENTRIES];
   logic [ID_W-1:0]   id_sel;

   // An id of zero marks an empty entry; reset clears only the ids, not the addresses.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            ids_ff[i] <= ID_EMPTY;
         end
      end else if (wr.en) begin
         ids_ff[wr.index[IDX_W-1:0]] <= wr.id;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         addrs_ff[wr.index[IDX_W-1:0]] <= wr.address;
      end
   end

   assign id_sel     = ids_ff[rd_index];
   assign rd_id      = id_sel;
   assign rd_address = (id_sel != ID_EMPTY) ? addrs_ff[rd_index] : '0;

endmodule
